### hw/rtl/percent_decoder_assert.svh
// Assertion macros used by the checker file of the percent decoder.
`ifndef PERCENT_DECODER_ASSERT_SVH
`define PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("percent decoder check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("percent decoder check failed");

// Next-cycle implication that is also checked across reset.
`define PCT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("percent decoder reset check failed");

`endif

### hw/rtl/pct_pkg.sv
package pct_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int IDX_W       = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    typedef logic [7:0] byte_t;

    // The decoded bytes that one input word causes, first byte at index 0.
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] bytes;
        logic  [IDX_W-1:0]       count;
        logic                    last;
    } pct_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pct_fifo_stat_t;

endpackage

### hw/rtl/percent_decoder.sv
// An accepted word is written into the queue; its first decoded byte is then registered onto m_.
// Throughput: one input word per cycle while the four-entry queue has room; the output stage
// sends one decoded byte per cycle while m_ready is high, so a word that yields two or three
// bytes holds that stage until all are sent. Words that only open or extend an escape push no entry.
// Reset (aresetn low, synchronous) clears the escape state, empties the queue and drops m_valid.
module percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_end,
    output logic       m_message_end
);
    import pct_pkg::*;

    pct_fifo_stat_t stat;
    pct_entry_t     push_entry;
    pct_entry_t     head_entry;
    logic           push;
    logic           pop;

    pct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .stat       (stat),
        .push       (push),
        .push_entry (push_entry)
    );

    pct_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .stat       (stat)
    );

    pct_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_entry    (head_entry),
        .stat          (stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_end     (m_run_end),
        .m_message_end (m_message_end)
    );

endmodule

### hw/rtl/pct_front.sv
module pct_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_in_byte,
    input  logic                    s_in_last,
    input  pct_pkg::pct_fifo_stat_t stat,
    output logic                    push,
    output pct_pkg::pct_entry_t     push_entry
);
    import pct_pkg::*;

    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_PCT   = 8'h25;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CH_LA    = 8'h61;
    localparam byte_t CH_LF    = 8'h66;
    localparam byte_t CH_UA    = 8'h41;
    localparam byte_t CH_UF    = 8'h46;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t phase_reg, phase_next;
    byte_t  held_reg, held_next;
    logic   accept;

    function automatic logic is_hex(input byte_t c);
        return c inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
    endfunction

    // Digits keep their value in the low nibble; both letter ranges sit at one past a nibble
    // boundary, so adding nine gives ten for the first letter.
    function automatic logic [3:0] hex_value(input byte_t c);
        return (c <= CH_9) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    assign s_ready = !stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pct_entry_t       ent;
        logic [IDX_W-1:0] cnt;
        logic             from_idle;
        ent        = '0;
        cnt        = '0;
        from_idle  = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT: begin
                if (is_hex(s_in_byte)) begin
                    held_next  = s_in_byte;
                    phase_next = PH_DIGIT;
                end else begin
                    ent.bytes[cnt] = CH_PCT;
                    cnt            = cnt + 1'b1;
                    phase_next     = PH_IDLE;
                    from_idle      = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (is_hex(s_in_byte)) begin
                    ent.bytes[cnt] = {hex_value(held_reg), hex_value(s_in_byte)};
                    cnt            = cnt + 1'b1;
                end else begin
                    ent.bytes[cnt] = CH_PCT;
                    cnt            = cnt + 1'b1;
                    ent.bytes[cnt] = held_reg;
                    cnt            = cnt + 1'b1;
                    from_idle      = 1'b1;
                end
                phase_next = PH_IDLE;
                held_next  = '0;
            end
            default: begin
                phase_next = PH_IDLE;
                from_idle  = 1'b1;
            end
        endcase
        if (from_idle) begin
            if (s_in_byte == CH_PLUS) begin
                ent.bytes[cnt] = CH_SPACE;
                cnt            = cnt + 1'b1;
            end else if (s_in_byte == CH_PCT) begin
                phase_next = PH_PCT;
            end else begin
                ent.bytes[cnt] = s_in_byte;
                cnt            = cnt + 1'b1;
            end
        end
        // An escape still open at the end of the message goes out literally.
        if (s_in_last) begin
            if (phase_next == PH_PCT) begin
                ent.bytes[cnt] = CH_PCT;
                cnt            = cnt + 1'b1;
            end else if (phase_next == PH_DIGIT) begin
                ent.bytes[cnt] = CH_PCT;
                cnt            = cnt + 1'b1;
                ent.bytes[cnt] = held_next;
                cnt            = cnt + 1'b1;
            end
            phase_next = PH_IDLE;
            held_next  = '0;
        end
        ent.count  = cnt;
        ent.last   = s_in_last;
        push_entry = ent;
        push       = accept && (cnt != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

### hw/rtl/pct_fifo.sv
module pct_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  pct_pkg::pct_entry_t     push_entry,
    input  logic                    pop,
    output pct_pkg::pct_entry_t     head_entry,
    output pct_pkg::pct_fifo_stat_t stat
);
    import pct_pkg::*;

    pct_entry_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_entry = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(FIFO_DEPTH));

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/pct_back.sv
module pct_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pct_pkg::pct_entry_t     head_entry,
    input  pct_pkg::pct_fifo_stat_t stat,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_run_end,
    output logic                    m_message_end
);
    import pct_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    byte_t            out_byte_reg, out_byte_next;
    logic             run_end_reg, run_end_next;
    logic             msg_end_reg, msg_end_next;
    logic             load;
    logic             is_final;

    assign load     = !m_valid_reg || m_ready;
    assign is_final = (idx_reg == head_entry.count - 1'b1);
    assign pop      = load && !stat.empty && is_final;

    always_comb begin
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg;
        out_byte_next = out_byte_reg;
        run_end_next  = run_end_reg;
        msg_end_next  = msg_end_reg;
        if (load) begin
            m_valid_next = !stat.empty;
            if (!stat.empty) begin
                out_byte_next = head_entry.bytes[idx_reg];
                run_end_next  = is_final;
                msg_end_next  = is_final && head_entry.last;
                idx_next      = is_final ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        run_end_reg  <= run_end_next;
        msg_end_reg  <= msg_end_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_run_end     = run_end_reg;
    assign m_message_end = msg_end_reg;

endmodule

### hw/rtl/pct_checker.sv
`include "percent_decoder_assert.svh"

module pct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_in_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_end,
    input logic       m_message_end
);

    logic [9:0] m_payload;

    assign m_payload = {m_out_byte, m_run_end, m_message_end};

    // After reset nothing is pending and the input side is open.
    `PCT_ASSERT_NEXT_ALWAYS(a_reset_clears, !aresetn, !m_valid && s_ready)

    // A stalled result word holds its payload.
    `PCT_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_payload))

    // The rest of a word's results follows without a gap.
    `PCT_ASSERT_NEXT(a_run_continues, m_valid && m_ready && !m_run_end, m_valid)

    // The end of a message always closes a run.
    `PCT_ASSERT_IMP(a_msg_end_run, m_valid && m_message_end, m_run_end)

endmodule

bind percent_decoder pct_checker u_pct_checker (.*);
